@@ sv/rcf_pkg.sv @@
// Package for the ring channel FIFO: operation and status codes, register
// map, configuration struct and the element width mask function.
// No dependencies; every other file of the block imports it.
package rcf_pkg;

    // Defaults for the top level parameters
    localparam int MAX_DEPTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 64;

    // Fixed field widths of the item channels
    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 10;
    localparam int FREE_W  = 11;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CAPL_W  = 4;
    localparam int EWSEL_W = 2;

    localparam logic [CAPL_W-1:0]  CAPL_RESET  = 4'd10;
    localparam logic [EWSEL_W-1:0] EWSEL_RESET = 2'd3;

    typedef enum logic [0:0] {
        REG_CAPACITY_LOG2     = 1'b0,
        REG_ELEMENT_WIDTH_SEL = 1'b1
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_GET   = 2'd2,
        OP_SET   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [EWSEL_W-1:0] {
        EW_BYTE = 2'd0,
        EW_HALF = 2'd1,
        EW_WORD = 2'd2,
        EW_LONG = 2'd3
    } ew_sel_t;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } phase_t;

    typedef struct packed {
        logic [CAPL_W-1:0]  capacity_log2;
        logic [EWSEL_W-1:0] element_width_sel;
    } cfg_t;

    // Mask for the selected element width, limited to the stored data width
    function automatic logic [VALUE_W-1:0] width_mask(input logic [EWSEL_W-1:0] sel,
                                                      input int dw);
        int w;
        logic [VALUE_W-1:0] m;
        case (ew_sel_t'(sel))
            EW_BYTE: w = 8;
            EW_HALF: w = 16;
            EW_WORD: w = 32;
            default: w = 64;
        endcase
        if (dw < w) begin
            w = dw;
        end
        if (w >= VALUE_W) begin
            m = '1;
        end else begin
            m = (VALUE_W'(1) << w) - VALUE_W'(1);
        end
        return m;
    endfunction

endpackage

@@ sv/rcf_ifs.sv @@
// Item channel interfaces of the ring channel FIFO: command in, response out.
// Depends on rcf_pkg for the field widths.
interface rcf_cmd_if
    import rcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] slot_index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output slot_index, output value, input ready);
    modport sink   (input valid, input op, input slot_index, input value, output ready);
endinterface

interface rcf_rsp_if
    import rcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] read_value;
    logic [OCC_W-1:0]   occupancy;
    logic [FREE_W-1:0]  free_slots;
    logic               full_flag;
    logic               index_occupied;

    modport source (output valid, output status, output read_value, output occupancy,
                    output free_slots, output full_flag, output index_occupied,
                    input ready);
    modport sink   (input valid, input status, input read_value, input occupancy,
                    input free_slots, input full_flag, input index_occupied,
                    output ready);
endinterface

@@ sv/ring_channel_fifo_top.sv @@
// Ring channel FIFO top level. An accepted item goes through the input register
// into the result register, where its result is held until taken. Throughput:
// one item per cycle while the response side is not stalled, set by the
// single-port slot store access. Reset: asynchronous, active low; afterwards a
// clearing sweep zeroes every slot of the slot store, during which no item is
// accepted. Depends on rcf_pkg, rcf_ifs, rcf_cfg, rcf_slot_ram, rcf_core.
module ring_channel_fifo_top
    import rcf_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    rcf_cmd_if.sink            cmd,
    rcf_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);

    cfg_t                  cfg;
    logic                  ram_en;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Configuration registers
    rcf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Slot store
    rcf_slot_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Pointer control and item pipeline
    rcf_core #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule

@@ sv/rcf_cfg.sv @@
// APB-style configuration registers: capacity_log2 and element_width_sel.
// Depends on rcf_pkg.
module rcf_cfg
    import rcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t sel;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Write a register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity_log2     <= CAPL_RESET;
            cfg_reg.element_width_sel <= EWSEL_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_CAPACITY_LOG2:     cfg_reg.capacity_log2     <= pwdata[CAPL_W-1:0];
                REG_ELEMENT_WIDTH_SEL: cfg_reg.element_width_sel <= pwdata[EWSEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (sel)
            REG_CAPACITY_LOG2:     prdata = PDATA_W'(cfg_reg.capacity_log2);
            REG_ELEMENT_WIDTH_SEL: prdata = PDATA_W'(cfg_reg.element_width_sel);
            default:               prdata = '0;
        endcase
    end

endmodule

@@ sv/rcf_slot_ram.sv @@
// Single-port slot store with read-before-write and registered read data.
// Depends on rcf_pkg for the parameter defaults.
module rcf_slot_ram
    import rcf_pkg::*;
#(
    parameter int DEPTH = MAX_DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Return the old entry and write the new one at the same address
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

@@ sv/rcf_core.sv @@
// Ring FIFO control: clearing sweep, input register, pointer update, result
// register, and the port of the slot store. Depends on rcf_pkg and rcf_ifs.
module rcf_core
    import rcf_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    rcf_cmd_if.sink                      cmd,
    rcf_rsp_if.source                    rsp,
    output logic                         ram_en,
    output logic                         ram_we,
    output logic [$clog2(MAX_DEPTH)-1:0] ram_addr,
    output logic [DATA_WIDTH-1:0]        ram_wdata,
    input  logic [DATA_WIDTH-1:0]        ram_rdata
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);
    localparam int IDX_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int WIDE_W = 32;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEPTH - 1);

    // Clearing sweep
    phase_t              phase_reg, phase_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                clearing;

    // Input register
    logic                a_valid_reg;
    op_t                 a_op_reg;
    logic [INDEX_W-1:0]  a_idx_reg;
    logic [VALUE_W-1:0]  a_value_reg;

    // Pointers
    logic [ADDR_W-1:0]   head_reg, tail_reg;

    // Result register (read data sits in the slot store)
    logic                b_valid_reg;
    status_t             b_status_reg;
    logic                b_rv_en_reg;
    logic [OCC_W-1:0]    b_occ_reg;
    logic [FREE_W-1:0]   b_free_reg;
    logic                b_full_reg;
    logic                b_hit_reg;

    // Working signals
    logic                advance;
    logic [4:0]          eff_log2;
    logic [ADDR_W:0]     cap, m_full;
    logic [ADDR_W-1:0]   m, h, t, cnt, idx, addr, h_n, t_n, cnt_n;
    logic [IDX_W-1:0]    idx_wide;
    logic [ADDR_W:0]     free_old, free_n;
    logic                full_old;
    status_t             status_n;
    logic                rv_en_n, op_we;
    logic [VALUE_W-1:0]  wm_in, wm_out, v_m;
    logic [DATA_WIDTH-1:0] op_wdata;
    logic [WIDE_W-1:0]   cnt_wide, free_wide;

    // Sweep state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Sweep next state: zero one slot a cycle, then run
    always_comb
    begin
        phase_next    = phase_reg;
        clr_addr_next = clr_addr_reg;
        clearing      = 1'b0;
        case (phase_reg)
            PH_CLEAR:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    phase_next = PH_RUN;
                end
            end
            PH_RUN: ;
            default: phase_next = PH_CLEAR;
        endcase
    end

    // Handshake: advance when the result register is free or being emptied
    assign advance   = a_valid_reg && (!b_valid_reg || rsp.ready);
    assign cmd.ready = (phase_reg == PH_RUN) && (!a_valid_reg || advance);

    // Effective capacity and masks
    always_comb
    begin
        eff_log2 = 5'(cfg.capacity_log2);
        if (eff_log2 < 5'd1)
        begin
            eff_log2 = 5'd1;
        end
        if (eff_log2 > 5'(ADDR_W))
        begin
            eff_log2 = 5'(ADDR_W);
        end
    end

    assign cap      = (ADDR_W+1)'(1) << eff_log2;
    assign m_full   = cap - (ADDR_W+1)'(1);
    assign m        = m_full[ADDR_W-1:0];
    assign h        = head_reg & m;
    assign t        = tail_reg & m;
    assign cnt      = (t - h) & m;
    assign idx_wide = IDX_W'(a_idx_reg);
    assign idx      = idx_wide[ADDR_W-1:0] & m;
    assign free_old = cap - {1'b0, cnt};
    assign full_old = free_old <= (ADDR_W+1)'(1);
    assign wm_in    = width_mask(cfg.element_width_sel, DATA_WIDTH);
    assign v_m      = a_value_reg & wm_in;

    // Decode the operation
    always_comb
    begin
        addr     = idx;
        h_n      = h;
        t_n      = t;
        status_n = ST_OK;
        rv_en_n  = 1'b0;
        op_we    = 1'b1;
        op_wdata = '0;
        case (a_op_reg)
            OP_WRITE:
            begin
                addr     = t;
                op_wdata = v_m[DATA_WIDTH-1:0];
                if (full_old)
                begin
                    status_n = ST_FULL;
                    op_we    = 1'b0;
                end
                else
                begin
                    t_n = (t + ADDR_W'(1)) & m;
                end
            end
            OP_READ:
            begin
                addr = h;
                if (cnt == '0)
                begin
                    status_n = ST_EMPTY;
                    op_we    = 1'b0;
                end
                else
                begin
                    rv_en_n = 1'b1;
                    h_n     = (h + ADDR_W'(1)) & m;
                end
            end
            OP_GET:
            begin
                rv_en_n = 1'b1;
            end
            OP_SET:
            begin
                op_wdata = v_m[DATA_WIDTH-1:0];
            end
            default: op_we = 1'b0;
        endcase
    end

    assign cnt_n     = (t_n - h_n) & m;
    assign free_n    = cap - {1'b0, cnt_n};
    assign cnt_wide  = WIDE_W'(cnt_n);
    assign free_wide = WIDE_W'(free_n);

    // Slot store port: sweep writes zeros, items read and write one slot
    assign ram_en    = clearing || advance;
    assign ram_we    = clearing || (advance && op_we);
    assign ram_addr  = clearing ? clr_addr_reg : addr;
    assign ram_wdata = clearing ? '0 : op_wdata;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            a_op_reg    <= op_t'(cmd.op);
            a_idx_reg   <= cmd.slot_index;
            a_value_reg <= cmd.value;
        end
    end

    // Pointers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                head_reg    <= h_n;
                tail_reg    <= t_n;
                b_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_status_reg <= status_n;
            b_rv_en_reg  <= rv_en_n;
            b_occ_reg    <= cnt_wide[OCC_W-1:0];
            b_free_reg   <= free_wide[FREE_W-1:0];
            b_full_reg   <= free_n <= (ADDR_W+1)'(1);
            b_hit_reg    <= ((addr - h_n) & m) < cnt_n;
        end
    end

    // Drive the response channel
    assign wm_out             = width_mask(cfg.element_width_sel, DATA_WIDTH);
    assign rsp.valid          = b_valid_reg;
    assign rsp.status         = b_status_reg;
    assign rsp.read_value     = b_rv_en_reg ? (VALUE_W'(ram_rdata) & wm_out) : '0;
    assign rsp.occupancy      = b_occ_reg;
    assign rsp.free_slots     = b_free_reg;
    assign rsp.full_flag      = b_full_reg;
    assign rsp.index_occupied = b_hit_reg;

    // A refused write leaves the ring full
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.full_flag)
        else $error("full refusal without full flag");

    // A refused read leaves the ring empty
    a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0 && !rsp.index_occupied)
        else $error("empty refusal with entries held");

    // Pointers move only when an item is processed
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(head_reg) && $stable(tail_reg))
        else $error("pointer moved without an item");

    // No item is taken during the clearing sweep
    a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !a_valid_reg && !b_valid_reg)
        else $error("item in flight during clearing sweep");

endmodule
